FILE: src/mbbf_pkg.sv
`default_nettype none

package mbbf_pkg;

    // Built storage depth and the width of the capacity register.
    localparam int DEPTH_DEFAULT = 256;
    localparam int CAP_W         = 9;

    // Action codes carried by an input word.
    typedef enum logic [1:0] {
        ACT_PUSH       = 2'd0,
        ACT_PUSH_FORCE = 2'd1,
        ACT_POP        = 2'd2,
        ACT_FLUSH      = 2'd3
    } t_action;

    // Fill state codes reported with every result word.
    localparam logic [1:0] FILL_EMPTY   = 2'd0;
    localparam logic [1:0] FILL_PARTIAL = 2'd1;
    localparam logic [1:0] FILL_FULL    = 2'd2;

    // Register index of the capacity register.
    localparam logic REG_CAPACITY = 1'b0;

endpackage

`default_nettype wire

FILE: src/mirror_bit_byte_fifo.sv
// Pipeline: an accepted input word passes through the read-wait stage, which takes the
// registered read of the storage memory, and then through the output register. A stalled
// result word holds the input off until it moves.
// Throughput: one word per cycle while the result side does not stall; the storage memory
// does one write and one registered read per cycle, and result metadata waits one stage for the read data.
// Reset: synchronous, active low; both positions and wrap bits clear to zero and the
// capacity register returns to the built depth. Storage contents are not cleared.
`default_nettype none

module mirror_bit_byte_fifo #(
    parameter int DEPTH = mbbf_pkg::DEPTH_DEFAULT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input words.
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_action,
    input  wire logic [7:0]  i_data_byte,
    // Result words.
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_accepted,
    output logic [7:0]       o_read_data,
    output logic             o_overwrote,
    output logic [1:0]       o_fill_state,
    output logic [8:0]       o_fill_count,
    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int CW = mbbf_pkg::CAP_W;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = (AW > CW) ? AW : CW;
    localparam int CAP_MAX = (1 << CW) - 1;
    localparam logic [CW-1:0] CAP_RESET = (DEPTH > CAP_MAX) ? CW'(CAP_MAX) : CW'(DEPTH);

    // Storage memory, read through a register.
    logic [7:0]    r_mem [DEPTH];
    logic [7:0]    r_mem_q;

    // FIFO positions and mirror bits.
    logic [AW-1:0] r_rd_pos, n_rd_pos;
    logic [AW-1:0] r_wr_pos, n_wr_pos;
    logic          r_rd_wrap, n_rd_wrap;
    logic          r_wr_wrap, n_wr_wrap;
    logic [CW-1:0] r_cap;

    // Stage waiting for the memory read data.
    logic          r_a_valid;
    logic          r_a_acc;
    logic          r_a_ow;
    logic          r_a_rd;

    logic          r_out_valid;
    logic          r_out_acc;
    logic [7:0]    r_out_data;
    logic          r_out_ow;
    logic [1:0]    r_out_state;
    logic [8:0]    r_out_count;

    logic          in_fire;
    logic          a_move;
    logic          cfg_wr;
    logic [CW-1:0] cap_use;
    logic [LW-1:0] cap_last;
    logic          is_empty;
    logic          is_full;
    logic          do_write;
    logic          do_pop;
    logic          n_acc;
    logic          n_ow;
    logic [1:0]    fill_state;
    logic [LW-1:0] fill_count;
    logic [LW-1:0] rd_ext;
    logic [LW-1:0] wr_ext;
    mbbf_pkg::t_action act;

    // Next position and wrap bit after one step around the ring.
    function automatic logic [AW:0] step_pos(input logic [AW-1:0] pos, input logic wrap,
                                             input logic [LW-1:0] last);
        logic [AW:0] res;
        if (LW'(pos) >= last) begin
            res = {~wrap, {AW{1'b0}}};
        end else begin
            res = {wrap, pos + AW'(1)};
        end
        return res;
    endfunction

    // Handshakes.
    assign a_move  = r_a_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_a_valid || a_move;
    assign in_fire = i_valid && o_ready;
    assign cfg_wr  = psel && penable && pwrite && (paddr[2] == mbbf_pkg::REG_CAPACITY);
    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == mbbf_pkg::REG_CAPACITY) ? {{(32-CW){1'b0}}, r_cap} : '0;

    // Capacity in use, with zero acting as one and large values clamped to the depth.
    always_comb begin
        if (r_cap == '0) begin
            cap_use = CW'(1);
        end else if (17'(r_cap) > 17'(DEPTH)) begin
            cap_use = CAP_RESET;
        end else begin
            cap_use = r_cap;
        end
        cap_last = LW'(cap_use) - LW'(1);
    end

    // Fill state from the current positions.
    assign rd_ext   = LW'(r_rd_pos);
    assign wr_ext   = LW'(r_wr_pos);
    assign is_empty = (r_rd_pos == r_wr_pos) && (r_rd_wrap == r_wr_wrap);
    assign is_full  = (r_rd_pos == r_wr_pos) && (r_rd_wrap != r_wr_wrap);

    always_comb begin
        if (is_empty) begin
            fill_state = mbbf_pkg::FILL_EMPTY;
            fill_count = '0;
        end else if (is_full) begin
            fill_state = mbbf_pkg::FILL_FULL;
            fill_count = LW'(cap_use);
        end else begin
            fill_state = mbbf_pkg::FILL_PARTIAL;
            if (wr_ext > rd_ext) begin
                fill_count = wr_ext - rd_ext;
            end else begin
                fill_count = LW'(cap_use) - (rd_ext - wr_ext);
            end
        end
    end

    // Action decode and next positions.
    assign act = mbbf_pkg::t_action'(i_action);

    always_comb begin
        do_write  = 1'b0;
        do_pop    = 1'b0;
        n_acc     = 1'b0;
        n_ow      = 1'b0;
        n_rd_pos  = r_rd_pos;
        n_rd_wrap = r_rd_wrap;
        n_wr_pos  = r_wr_pos;
        n_wr_wrap = r_wr_wrap;
        unique case (act)
            mbbf_pkg::ACT_PUSH: begin
                if (!is_full) begin
                    do_write = 1'b1;
                    n_acc    = 1'b1;
                    {n_wr_wrap, n_wr_pos} = step_pos(r_wr_pos, r_wr_wrap, cap_last);
                end
            end
            mbbf_pkg::ACT_PUSH_FORCE: begin
                do_write = 1'b1;
                n_acc    = 1'b1;
                {n_wr_wrap, n_wr_pos} = step_pos(r_wr_pos, r_wr_wrap, cap_last);
                if (is_full) begin
                    n_ow = 1'b1;
                    {n_rd_wrap, n_rd_pos} = step_pos(r_rd_pos, r_rd_wrap, cap_last);
                end
            end
            mbbf_pkg::ACT_POP: begin
                if (!is_empty) begin
                    do_pop = 1'b1;
                    n_acc  = 1'b1;
                    {n_rd_wrap, n_rd_pos} = step_pos(r_rd_pos, r_rd_wrap, cap_last);
                end
            end
            mbbf_pkg::ACT_FLUSH: begin
                n_acc     = 1'b1;
                n_rd_pos  = '0;
                n_rd_wrap = 1'b0;
                n_wr_pos  = '0;
                n_wr_wrap = 1'b0;
            end
            default: begin
                n_acc = 1'b0;
            end
        endcase
    end

    // Storage memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (in_fire && do_write) begin
            r_mem[r_wr_pos] <= i_data_byte;
        end
        if (in_fire && do_pop) begin
            r_mem_q <= r_mem[r_rd_pos];
        end
    end

    // Positions, wrap bits and the capacity register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pos  <= '0;
            r_wr_pos  <= '0;
            r_rd_wrap <= 1'b0;
            r_wr_wrap <= 1'b0;
            r_cap     <= CAP_RESET;
        end else if (cfg_wr) begin
            r_cap     <= pwdata[CW-1:0];
            r_rd_pos  <= '0;
            r_wr_pos  <= '0;
            r_rd_wrap <= 1'b0;
            r_wr_wrap <= 1'b0;
        end else if (in_fire) begin
            r_rd_pos  <= n_rd_pos;
            r_wr_pos  <= n_wr_pos;
            r_rd_wrap <= n_rd_wrap;
            r_wr_wrap <= n_wr_wrap;
        end
    end

    // Stage that waits for the registered read data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_fire) begin
            r_a_valid <= 1'b1;
        end else if (a_move) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_a_acc <= n_acc;
            r_a_ow  <= n_ow;
            r_a_rd  <= do_pop;
        end
    end

    // Output register; the fill figures come from the positions this word left behind.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (a_move) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_move) begin
            r_out_acc   <= r_a_acc;
            r_out_data  <= r_a_rd ? r_mem_q : 8'd0;
            r_out_ow    <= r_a_ow;
            r_out_state <= fill_state;
            r_out_count <= fill_count[8:0];
        end
    end

    assign o_valid      = r_out_valid;
    assign o_accepted   = r_out_acc;
    assign o_read_data  = r_out_data;
    assign o_overwrote  = r_out_ow;
    assign o_fill_state = r_out_state;
    assign o_fill_count = r_out_count;

endmodule

`default_nettype wire

FILE: dv/mbbf_tb_pkg.sv
package mbbf_tb_pkg;

    // One result word as the FIFO reports it.
    typedef struct packed {
        logic       accepted;
        logic [7:0] read_data;
        logic       overwrote;
        logic [1:0] fill_state;
        logic [8:0] fill_count;
    } t_fifo_result;

    // Mirror-bit byte FIFO tracker: keeps its own copy of the ring and the
    // capacity, and lines up the result word that each accepted word must produce.
    class byte_ring_tracker;
        logic [7:0]   ring [mbbf_pkg::DEPTH_DEFAULT];
        int unsigned  rd_pos;
        int unsigned  wr_pos;
        bit           rd_wrap;
        bit           wr_wrap;
        logic [8:0]   capacity_reg;
        t_fifo_result owed_results[$];
        int unsigned  failures;

        function new();
            capacity_reg = 9'(mbbf_pkg::DEPTH_DEFAULT);
            failures     = 0;
            clear_ring();
        endfunction

        function void clear_ring();
            rd_pos  = 0;
            wr_pos  = 0;
            rd_wrap = 1'b0;
            wr_wrap = 1'b0;
        endfunction

        // A capacity write empties the ring but keeps the stored bytes.
        function void set_capacity(logic [8:0] value);
            capacity_reg = value;
            clear_ring();
        endfunction

        // Slots in use: zero acts as one, anything above the built depth as the depth.
        function int unsigned slots();
            if (capacity_reg == 0)
                return 1;
            if (capacity_reg > mbbf_pkg::DEPTH_DEFAULT)
                return mbbf_pkg::DEPTH_DEFAULT;
            return capacity_reg;
        endfunction

        function logic [1:0] occupancy_state();
            if (rd_pos != wr_pos)
                return mbbf_pkg::FILL_PARTIAL;
            return (rd_wrap == wr_wrap) ? mbbf_pkg::FILL_EMPTY : mbbf_pkg::FILL_FULL;
        endfunction

        function logic [8:0] occupancy();
            logic [1:0] st;
            st = occupancy_state();
            if (st == mbbf_pkg::FILL_EMPTY)
                return 9'd0;
            if (st == mbbf_pkg::FILL_FULL)
                return 9'(slots());
            if (wr_pos > rd_pos)
                return 9'(wr_pos - rd_pos);
            return 9'(slots() - (rd_pos - wr_pos));
        endfunction

        // Each position flips its wrap bit when it steps past the last slot.
        function void bump_write();
            if (wr_pos >= slots() - 1) begin
                wr_pos  = 0;
                wr_wrap = ~wr_wrap;
            end else begin
                wr_pos++;
            end
        endfunction

        function void bump_read();
            if (rd_pos >= slots() - 1) begin
                rd_pos  = 0;
                rd_wrap = ~rd_wrap;
            end else begin
                rd_pos++;
            end
        endfunction

        // Applies one accepted word and queues the result it must produce.
        function void take_word(mbbf_pkg::t_action act, logic [7:0] data_byte);
            t_fifo_result r;
            logic [1:0]   was;
            r   = '0;
            was = occupancy_state();
            case (act)
                mbbf_pkg::ACT_PUSH: begin
                    if (was != mbbf_pkg::FILL_FULL) begin
                        ring[wr_pos] = data_byte;
                        bump_write();
                        r.accepted = 1'b1;
                    end
                end
                mbbf_pkg::ACT_PUSH_FORCE: begin
                    ring[wr_pos] = data_byte;
                    bump_write();
                    if (was == mbbf_pkg::FILL_FULL) begin
                        bump_read();
                        r.overwrote = 1'b1;
                    end
                    r.accepted = 1'b1;
                end
                mbbf_pkg::ACT_POP: begin
                    if (was != mbbf_pkg::FILL_EMPTY) begin
                        r.read_data = ring[rd_pos];
                        bump_read();
                        r.accepted = 1'b1;
                    end
                end
                mbbf_pkg::ACT_FLUSH: begin
                    clear_ring();
                    r.accepted = 1'b1;
                end
            endcase
            r.fill_state = occupancy_state();
            r.fill_count = occupancy();
            owed_results.push_back(r);
        endfunction

        function void report(string what, t_fifo_result want, t_fifo_result got);
            failures++;
            if (failures <= 10)
                $display({"%0t: %s: expected acc=%0d rd=%02h ow=%0d st=%0d cnt=%0d, ",
                          "got acc=%0d rd=%02h ow=%0d st=%0d cnt=%0d"},
                         $realtime, what,
                         want.accepted, want.read_data, want.overwrote,
                         want.fill_state, want.fill_count,
                         got.accepted, got.read_data, got.overwrote,
                         got.fill_state, got.fill_count);
        endfunction

        // Compares a delivered result word with the oldest one owed.
        function void compare_result(t_fifo_result got);
            t_fifo_result want;
            if (owed_results.size() == 0) begin
                report("result word with none outstanding", '0, got);
                return;
            end
            want = owed_results.pop_front();
            if (got.accepted !== want.accepted || got.read_data !== want.read_data ||
                got.overwrote !== want.overwrote || got.fill_state !== want.fill_state ||
                got.fill_count !== want.fill_count)
                report("result word mismatch", want, got);
        endfunction

        function int unsigned pending();
            return owed_results.size();
        endfunction
    endclass

endpackage

FILE: dv/tb_mirror_bit_byte_fifo.sv
module tb_mirror_bit_byte_fifo;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] CAPACITY_ADDR = 3'(4 * int'(mbbf_pkg::REG_CAPACITY));
    localparam int         HOLD_CYCLES   = 320;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_action = mbbf_pkg::ACT_PUSH;
    logic [7:0]  i_data_byte = 8'h00;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_accepted;
    logic [7:0]  o_read_data;
    logic        o_overwrote;
    logic [1:0]  o_fill_state;
    logic [8:0]  o_fill_count;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    mbbf_tb_pkg::byte_ring_tracker ring_model;
    bit               hold_request = 1'b0;
    int unsigned      burst_left = 0;

    mirror_bit_byte_fifo u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_action     (i_action),
        .i_data_byte  (i_data_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_accepted   (o_accepted),
        .o_read_data  (o_read_data),
        .o_overwrote  (o_overwrote),
        .o_fill_state (o_fill_state),
        .o_fill_count (o_fill_count),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // 12 ns clock.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Result side: every word taken is checked against the tracker.
    always @(posedge i_clk) begin : watch_results
        mbbf_tb_pkg::t_fifo_result seen;
        if (i_rst_n && o_valid && i_ready) begin
            seen.accepted   = o_accepted;
            seen.read_data  = o_read_data;
            seen.overwrote  = o_overwrote;
            seen.fill_state = o_fill_state;
            seen.fill_count = o_fill_count;
            ring_model.compare_result(seen);
        end
    end

    // Receiver stall pattern: stretches of always ready, coin flips and mostly stalled.
    // A hold request from the stimulus side stalls it for a long fixed stretch.
    initial begin : result_sink
        int unsigned mode;
        int unsigned mode_left;
        mode      = 0;
        mode_left = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_request = 1'b0;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(8, 64);
            end
            mode_left--;
            case (mode)
                0: i_ready <= 1'b1;
                1: i_ready <= 1'($urandom_range(0, 1));
                default: i_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Sender pacing: bursts of random length, some with no gap before them.
    task automatic pace();
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
    endtask

    // Offers one word and holds it until the FIFO takes it; returns at a falling edge.
    task automatic send_word(input mbbf_pkg::t_action act, input logic [7:0] data_byte);
        pace();
        i_valid     <= 1'b1;
        i_action    <= act;
        i_data_byte <= data_byte;
        do @(posedge i_clk); while (!o_ready);
        ring_model.take_word(act, data_byte);
        @(negedge i_clk);
    endtask

    // Stops offering words and waits until every owed result word has come back.
    task automatic drain();
        i_valid <= 1'b0;
        burst_left = 0;
        while (ring_model.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Register write through the configuration port: setup cycle, then access cycle.
    task automatic write_capacity(input logic [8:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAPACITY_ADDR;
        pwdata  <= 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        ring_model.set_capacity(value);
    endtask

    function automatic mbbf_pkg::t_action pick_action(input bit fill_bias);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (fill_bias)
            return (r < 60) ? mbbf_pkg::ACT_PUSH : (r < 85) ? mbbf_pkg::ACT_PUSH_FORCE :
                   (r < 97) ? mbbf_pkg::ACT_POP : mbbf_pkg::ACT_FLUSH;
        return (r < 15) ? mbbf_pkg::ACT_PUSH : (r < 25) ? mbbf_pkg::ACT_PUSH_FORCE :
               (r < 97) ? mbbf_pkg::ACT_POP : mbbf_pkg::ACT_FLUSH;
    endfunction

    // One capacity setting: optionally a run of pushes that fills the ring, then
    // segments that lean toward filling or toward draining.
    task automatic run_phase(input logic [8:0] cap, input int unsigned n_words,
                             input bit fill_first, input bit long_hold);
        int unsigned done;
        int unsigned seg_len;
        int unsigned slots_now;
        bit          bias;
        drain();
        write_capacity(cap);
        slots_now = ring_model.slots();
        done = 0;
        if (long_hold)
            hold_request = 1'b1;
        if (fill_first) begin
            repeat (slots_now + 4) begin
                send_word(($urandom_range(0, 3) == 0) ? mbbf_pkg::ACT_PUSH_FORCE
                                                      : mbbf_pkg::ACT_PUSH,
                          8'($urandom));
                done++;
            end
        end
        while (done < n_words) begin
            seg_len = $urandom_range(4, 2 * slots_now + 6);
            bias    = 1'($urandom_range(0, 1));
            for (int i = 0; i < seg_len && done < n_words; i++) begin
                send_word(pick_action(bias), 8'($urandom));
                done++;
            end
        end
    endtask

    // Main sequence.
    initial begin
        ring_model = new();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Built-depth capacity straight out of reset: pop on empty, then a round trip.
        send_word(mbbf_pkg::ACT_POP, 8'hFF);
        send_word(mbbf_pkg::ACT_PUSH, 8'hFF);
        send_word(mbbf_pkg::ACT_POP, 8'h00);
        send_word(mbbf_pkg::ACT_FLUSH, 8'hC3);

        // Three slots: fill, refused push, overwrite when full, drain to empty.
        drain();
        write_capacity(9'd3);
        send_word(mbbf_pkg::ACT_PUSH, 8'h00);
        send_word(mbbf_pkg::ACT_PUSH, 8'hFF);
        send_word(mbbf_pkg::ACT_PUSH, 8'hA5);
        send_word(mbbf_pkg::ACT_PUSH, 8'h5A);
        send_word(mbbf_pkg::ACT_PUSH_FORCE, 8'h3C);
        send_word(mbbf_pkg::ACT_PUSH_FORCE, 8'hC3);
        send_word(mbbf_pkg::ACT_POP, 8'h12);
        send_word(mbbf_pkg::ACT_POP, 8'h34);
        send_word(mbbf_pkg::ACT_POP, 8'h56);
        send_word(mbbf_pkg::ACT_POP, 8'h78);
        send_word(mbbf_pkg::ACT_PUSH_FORCE, 8'h81);
        send_word(mbbf_pkg::ACT_PUSH, 8'h7E);
        send_word(mbbf_pkg::ACT_FLUSH, 8'hFF);
        send_word(mbbf_pkg::ACT_POP, 8'h00);
        send_word(mbbf_pkg::ACT_FLUSH, 8'h00);
        send_word(mbbf_pkg::ACT_PUSH_FORCE, 8'h01);
        send_word(mbbf_pkg::ACT_PUSH, 8'h80);
        send_word(mbbf_pkg::ACT_PUSH, 8'h42);
        send_word(mbbf_pkg::ACT_FLUSH, 8'h99);

        // Random phases over a range of capacities, out-of-range values included.
        // The built-depth phase also holds off the receiver until input stalls.
        run_phase(9'd256, 290, 1'b1, 1'b1);
        run_phase(9'd1, 50, 1'b0, 1'b0);
        run_phase(9'd0, 30, 1'b0, 1'b0);
        run_phase(9'd511, 40, 1'b0, 1'b0);
        run_phase(9'd2, 50, 1'b0, 1'b0);
        run_phase(9'd5, 50, 1'b1, 1'b0);
        run_phase(9'($urandom_range(3, 16)), 50, 1'b1, 1'b0);
        run_phase(9'($urandom_range(17, 64)), 80, 1'b1, 1'b0);

        drain();
        repeat (8) @(posedge i_clk);
        if (ring_model.failures == 0 && ring_model.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
